// ===== sv/pcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsm_pkg
// Shared opcodes, micro-operation codes, controller states and status bundle
// for the p-code stack machine core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsm_pkg;

  localparam logic [3:0] OP_LIT   = 4'd1;
  localparam logic [3:0] OP_OPR   = 4'd2;
  localparam logic [3:0] OP_LOD   = 4'd3;
  localparam logic [3:0] OP_STO   = 4'd4;
  localparam logic [3:0] OP_CAL   = 4'd5;
  localparam logic [3:0] OP_INC   = 4'd6;
  localparam logic [3:0] OP_JMP   = 4'd7;
  localparam logic [3:0] OP_JPC   = 4'd8;
  localparam logic [3:0] OP_WRITE = 4'd9;
  localparam logic [3:0] OP_READ  = 4'd10;
  localparam logic [3:0] OP_HALT  = 4'd11;

  localparam logic [3:0] OPR_RET = 4'd0;
  localparam logic [3:0] OPR_NEG = 4'd1;
  localparam logic [3:0] OPR_ADD = 4'd2;
  localparam logic [3:0] OPR_SUB = 4'd3;
  localparam logic [3:0] OPR_MUL = 4'd4;
  localparam logic [3:0] OPR_DIV = 4'd5;
  localparam logic [3:0] OPR_ODD = 4'd6;
  localparam logic [3:0] OPR_MOD = 4'd7;
  localparam logic [3:0] OPR_EQL = 4'd8;
  localparam logic [3:0] OPR_NEQ = 4'd9;
  localparam logic [3:0] OPR_LSS = 4'd10;
  localparam logic [3:0] OPR_LEQ = 4'd11;
  localparam logic [3:0] OPR_GTR = 4'd12;
  localparam logic [3:0] OPR_GEQ = 4'd13;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_RANGE = 2'd1;
  localparam logic [1:0] FLT_DIV0  = 2'd2;

  typedef enum logic [5:0] {
    U_NOP, U_CLEAR, U_ACCEPT, U_FAULT, U_EMIT, U_ADV, U_HALT,
    U_PUSH_M, U_PUSH_RV, U_INC, U_MOD_M, U_SET_PC, U_RD_SP,
    U_JPC_TAKE, U_JPC_SKIP, U_WRITE_OUT, U_WALK_RD, U_WALK_LD,
    U_RD_BM, U_LOD_WR, U_STO_WR, U_CAL_W1, U_CAL_W2, U_CAL_W3, U_CAL_W4,
    U_RD_BP2, U_RD_BP3, U_RET_GO, U_UN_WR, U_LD_C, U_LD_A,
    U_BIN_DIV0, U_BIN_DIV, U_BIN_DIVRES, U_BIN_ALU, U_BIN_WR
  } uop_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_WALK, S_WALK_LD, S_LOD_WR, S_STO_WR,
    S_CAL2, S_CAL3, S_CAL4, S_JPC, S_WRITE, S_RET1, S_RET2, S_UN,
    S_BIN1, S_BIN2, S_BIN3, S_BIN4, S_DIV_WAIT, S_PC_WAIT, S_EMIT
  } state_t;

  typedef struct packed {
    logic [3:0] op;
    logic       held;
    logic       opr_ret;
    logic       opr_un;
    logic       opr_bin;
    logic       opr_divmod;
    logic       ok_sp;
    logic       ok_spm1;
    logic       ok_spp1;
    logic       ok_sp4;
    logic       ok_bp3;
    logic       ok_walk;
    logic       ok_bm;
    logic       ok_nbp;
    logic       ok_inc;
    logic       lev_zero;
    logic       rd_zero;
    logic       c_zero;
    logic       div_done;
    logic       clr_last;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/pcsm_ram.sv =====
// ----------------------------------------------------------------------------
// pcsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/pcsm_div.sv =====
// ----------------------------------------------------------------------------
// pcsm_div
// Iterative 32-bit divider, one quotient bit per cycle, signed or unsigned.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        sgn,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic      [31:0] quo,
  output logic      [31:0] rem
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [31:0] r_r, r_nxt;
  logic [31:0] d_r, d_nxt;
  logic        negq_r, negq_nxt;
  logic        negr_r, negr_nxt;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {r_r, q_r[31]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      q_nxt    = (sgn && dividend[31]) ? 32'd0 - dividend : dividend;
      d_nxt    = (sgn && divisor[31]) ? 32'd0 - divisor : divisor;
      r_nxt    = '0;
      negq_nxt = sgn & (dividend[31] ^ divisor[31]);
      negr_nxt = sgn & dividend[31];
    end else if (busy_r) begin
      r_nxt   = ge ? diff[31:0] : trial[31:0];
      q_nxt   = {q_r[30:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    d_r    <= d_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
  end

  assign done = done_r;
  assign quo  = negq_r ? 32'd0 - q_r : q_r;
  assign rem  = negr_r ? 32'd0 - r_r : r_r;

endmodule

`default_nettype wire

// ===== sv/pcsm_dpath.sv =====
// ----------------------------------------------------------------------------
// pcsm_dpath
// Datapath: machine registers, data stack RAM, range checks, ALU, divider
// and the result register. Driven one micro-operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsm_dpath #(
  parameter int STACK_DEPTH = 1024,
  parameter int CODE_DEPTH  = 512
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pcsm_pkg::uop_t   uop,
  output pcsm_pkg::status_t     st,
  input  wire logic [3:0]       in_op,
  input  wire logic [3:0]       in_level,
  input  wire logic [31:0]      in_m,
  input  wire logic [31:0]      in_rv,
  output logic      [8:0]       res_pc,
  output logic      [10:0]      res_bp,
  output logic      [10:0]      res_sp,
  output logic                  res_wv,
  output logic      [31:0]      res_wval,
  output logic                  res_halt,
  output logic      [1:0]       res_fault
);

  import pcsm_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int PW  = AW + 1;
  localparam int PCW = $clog2(CODE_DEPTH);
  localparam logic signed [33:0] DEPTH_S = 34'(STACK_DEPTH);
  localparam bit PC_POW2 = (CODE_DEPTH & (CODE_DEPTH - 1)) == 0;

  function automatic logic in_rng(input logic signed [33:0] x);
    return (x >= 34'sd0) && (x < DEPTH_S);
  endfunction

  logic [PCW-1:0] pc_r, pc_nxt;
  logic [PW-1:0]  bp_r, bp_nxt;
  logic [PW-1:0]  sp_r, sp_nxt;
  logic           halt_r, halt_nxt;
  logic [1:0]     fault_r, fault_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  logic [3:0]     op_r, op_nxt;
  logic [3:0]     lev_r, lev_nxt;
  logic [31:0]    m_r, m_nxt;
  logic [31:0]    rv_r, rv_nxt;
  logic [31:0]    b_r, b_nxt;
  logic [31:0]    a_r, a_nxt;
  logic [31:0]    c_r, c_nxt;
  logic [31:0]    nbp_r, nbp_nxt;
  logic [31:0]    res_r, res_nxt;
  logic           wv_r, wv_nxt;
  logic [31:0]    wval_r, wval_nxt;
  logic [8:0]     opc_r, opc_nxt;
  logic [10:0]    obp_r, obp_nxt;
  logic [10:0]    osp_r, osp_nxt;
  logic           owv_r, owv_nxt;
  logic [31:0]    owval_r, owval_nxt;
  logic           ohalt_r, ohalt_nxt;
  logic [1:0]     ofault_r, ofault_nxt;
  logic [PCW-1:0] tgt_r, tgt_nxt;
  logic           tgt_rdy_r, tgt_rdy_nxt;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [31:0]    wdata;
  logic [AW-1:0]  raddr;
  logic [31:0]    rdata;

  logic           pc_go;
  logic           div_start;
  logic           div_sgn;
  logic [31:0]    div_a;
  logic [31:0]    div_d;
  logic           div_done;
  logic [31:0]    div_q;
  logic [31:0]    div_rm;

  logic signed [33:0] sp_s, b_s, m_s, bm_s, inc_s, bw_s, nbp_s;
  logic [PW-1:0]  sp_m1, sp_p1, sp_m2, sp_m3, sp_m4, bp_m2, bp_m3, bp_p1;
  logic [PCW-1:0] npc_inc;
  logic [63:0]    pc_ext, bp_ext, sp_ext;
  logic signed [31:0] a_s, c_s;
  logic signed [63:0] prod;
  logic [31:0]    alu;

  assign sp_s  = $signed({{(34-PW){1'b0}}, sp_r});
  assign b_s   = {{2{b_r[31]}}, b_r};
  assign m_s   = {{2{m_r[31]}}, m_r};
  assign nbp_s = {{2{nbp_r[31]}}, nbp_r};
  assign bm_s  = b_s - m_s;
  assign inc_s = sp_s - m_s;
  assign bw_s  = b_s - 34'sd1;
  assign sp_m1 = sp_r - PW'(1);
  assign sp_p1 = sp_r + PW'(1);
  assign sp_m2 = sp_r - PW'(2);
  assign sp_m3 = sp_r - PW'(3);
  assign sp_m4 = sp_r - PW'(4);
  assign bp_m2 = bp_r - PW'(2);
  assign bp_m3 = bp_r - PW'(3);
  assign bp_p1 = bp_r + PW'(1);
  assign npc_inc = (pc_r == PCW'(CODE_DEPTH - 1)) ? '0 : pc_r + PCW'(1);

  assign a_s  = $signed(a_r);
  assign c_s  = $signed(c_r);
  assign prod = a_s * c_s;

  always_comb begin
    case (m_r[3:0])
      OPR_ADD: alu = a_r + c_r;
      OPR_SUB: alu = a_r - c_r;
      OPR_MUL: alu = prod[31:0];
      OPR_EQL: alu = {31'd0, a_r == c_r};
      OPR_NEQ: alu = {31'd0, a_r != c_r};
      OPR_LSS: alu = {31'd0, a_s < c_s};
      OPR_LEQ: alu = {31'd0, a_s <= c_s};
      OPR_GTR: alu = {31'd0, a_s > c_s};
      OPR_GEQ: alu = {31'd0, a_s >= c_s};
      default: alu = '0;
    endcase
  end

  always_comb begin
    st.op         = op_r;
    st.held       = halt_r || (fault_r != FLT_NONE);
    st.opr_ret    = m_r == 32'(OPR_RET);
    st.opr_un     = (m_r == 32'(OPR_NEG)) || (m_r == 32'(OPR_ODD));
    st.opr_bin    = ($signed(m_r) >= $signed(32'(OPR_ADD))) &&
                    ($signed(m_r) <= $signed(32'(OPR_GEQ))) &&
                    (m_r != 32'(OPR_ODD));
    st.opr_divmod = (m_r == 32'(OPR_DIV)) || (m_r == 32'(OPR_MOD));
    st.ok_sp      = sp_r < PW'(STACK_DEPTH);
    st.ok_spm1    = sp_r != '0;
    st.ok_spp1    = (sp_s + 34'sd1) < DEPTH_S;
    st.ok_sp4     = sp_r >= PW'(4);
    st.ok_bp3     = bp_r >= PW'(3);
    st.ok_walk    = in_rng(bw_s);
    st.ok_bm      = in_rng(bm_s);
    st.ok_nbp     = in_rng(nbp_s);
    st.ok_inc     = (inc_s >= 34'sd0) && (inc_s <= DEPTH_S);
    st.lev_zero   = lev_r == 4'd0;
    st.rd_zero    = rdata == 32'd0;
    st.c_zero     = c_r == 32'd0;
    st.div_done   = div_done | tgt_rdy_r;
    st.clr_last   = clr_r == AW'(STACK_DEPTH - 1);
  end

  assign pc_ext = 64'(pc_r);
  assign bp_ext = 64'(bp_r);
  assign sp_ext = 64'(sp_r);

  always_comb begin
    pc_nxt    = pc_r;
    bp_nxt    = bp_r;
    sp_nxt    = sp_r;
    halt_nxt  = halt_r;
    fault_nxt = fault_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    lev_nxt   = lev_r;
    m_nxt     = m_r;
    rv_nxt    = rv_r;
    b_nxt     = b_r;
    a_nxt     = a_r;
    c_nxt     = c_r;
    nbp_nxt   = nbp_r;
    res_nxt   = res_r;
    wv_nxt    = wv_r;
    wval_nxt  = wval_r;
    opc_nxt   = opc_r;
    obp_nxt   = obp_r;
    osp_nxt   = osp_r;
    owv_nxt   = owv_r;
    owval_nxt = owval_r;
    ohalt_nxt = ohalt_r;
    ofault_nxt = ofault_r;
    tgt_nxt   = tgt_r;
    we        = 1'b0;
    waddr     = sp_r[AW-1:0];
    wdata     = '0;
    raddr     = sp_r[AW-1:0];
    pc_go     = 1'b0;
    div_start = 1'b0;
    div_sgn   = 1'b0;
    div_a     = m_r;
    div_d     = 32'(CODE_DEPTH);
    case (uop)
      U_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + AW'(1);
      end
      U_ACCEPT: begin
        op_nxt   = in_op;
        lev_nxt  = in_level;
        m_nxt    = in_m;
        rv_nxt   = in_rv;
        b_nxt    = 32'(bp_r);
        wv_nxt   = 1'b0;
        wval_nxt = '0;
      end
      U_FAULT:  fault_nxt = FLT_RANGE;
      U_ADV:    pc_nxt = npc_inc;
      U_HALT: begin
        halt_nxt = 1'b1;
        pc_nxt   = npc_inc;
      end
      U_PUSH_M, U_PUSH_RV: begin
        we     = 1'b1;
        waddr  = sp_m1[AW-1:0];
        wdata  = (uop == U_PUSH_M) ? m_r : rv_r;
        sp_nxt = sp_m1;
        pc_nxt = npc_inc;
      end
      U_INC: begin
        sp_nxt = inc_s[PW-1:0];
        pc_nxt = npc_inc;
      end
      U_MOD_M:  pc_go = 1'b1;
      U_SET_PC: pc_nxt = PC_POW2 ? tgt_r : div_rm[PCW-1:0];
      U_RD_SP:  raddr = sp_r[AW-1:0];
      U_JPC_TAKE: begin
        sp_nxt = sp_p1;
        pc_go  = 1'b1;
      end
      U_JPC_SKIP: begin
        sp_nxt = sp_p1;
        pc_nxt = npc_inc;
      end
      U_WRITE_OUT: begin
        wv_nxt   = 1'b1;
        wval_nxt = rdata;
        sp_nxt   = sp_p1;
        pc_nxt   = npc_inc;
      end
      U_WALK_RD: begin
        raddr   = bw_s[AW-1:0];
        lev_nxt = lev_r - 4'd1;
      end
      U_WALK_LD: b_nxt = rdata;
      U_RD_BM:   raddr = bm_s[AW-1:0];
      U_LOD_WR: begin
        we     = 1'b1;
        waddr  = sp_m1[AW-1:0];
        wdata  = rdata;
        sp_nxt = sp_m1;
        pc_nxt = npc_inc;
      end
      U_STO_WR: begin
        we     = 1'b1;
        waddr  = bm_s[AW-1:0];
        wdata  = rdata;
        sp_nxt = sp_p1;
        pc_nxt = npc_inc;
      end
      U_CAL_W1: begin
        we    = 1'b1;
        waddr = sp_m1[AW-1:0];
      end
      U_CAL_W2: begin
        we    = 1'b1;
        waddr = sp_m2[AW-1:0];
        wdata = b_r;
      end
      U_CAL_W3: begin
        we    = 1'b1;
        waddr = sp_m3[AW-1:0];
        wdata = 32'(bp_r);
      end
      U_CAL_W4: begin
        we     = 1'b1;
        waddr  = sp_m4[AW-1:0];
        wdata  = 32'(npc_inc);
        bp_nxt = sp_m1;
        pc_go  = 1'b1;
      end
      U_RD_BP2: raddr = bp_m2[AW-1:0];
      U_RD_BP3: begin
        raddr   = bp_m3[AW-1:0];
        nbp_nxt = rdata;
      end
      U_RET_GO: begin
        sp_nxt = bp_p1;
        bp_nxt = nbp_r[PW-1:0];
        pc_go  = 1'b1;
        div_a  = rdata;
      end
      U_UN_WR: begin
        we     = 1'b1;
        waddr  = sp_r[AW-1:0];
        wdata  = (m_r == 32'(OPR_NEG)) ? 32'd0 - rdata : {31'd0, rdata[0]};
        pc_nxt = npc_inc;
      end
      U_LD_C: begin
        c_nxt = rdata;
        raddr = sp_p1[AW-1:0];
      end
      U_LD_A: a_nxt = rdata;
      U_BIN_DIV0: begin
        we        = 1'b1;
        waddr     = sp_p1[AW-1:0];
        sp_nxt    = sp_p1;
        fault_nxt = FLT_DIV0;
        pc_nxt    = npc_inc;
      end
      U_BIN_DIV: begin
        div_start = 1'b1;
        div_sgn   = 1'b1;
        div_a     = a_r;
        div_d     = c_r;
      end
      U_BIN_DIVRES: begin
        we     = 1'b1;
        waddr  = sp_p1[AW-1:0];
        wdata  = (m_r == 32'(OPR_DIV)) ? div_q : div_rm;
        sp_nxt = sp_p1;
        pc_nxt = npc_inc;
      end
      U_BIN_ALU: res_nxt = alu;
      U_BIN_WR: begin
        we     = 1'b1;
        waddr  = sp_p1[AW-1:0];
        wdata  = res_r;
        sp_nxt = sp_p1;
        pc_nxt = npc_inc;
      end
      U_EMIT: begin
        opc_nxt    = pc_ext[8:0];
        obp_nxt    = bp_ext[10:0];
        osp_nxt    = sp_ext[10:0];
        owv_nxt    = wv_r;
        owval_nxt  = wv_r ? wval_r : 32'd0;
        ohalt_nxt  = halt_r;
        ofault_nxt = fault_r;
      end
      default: ;
    endcase
    // branch target: mask for a power-of-two code space, else divider remainder
    if (pc_go) begin
      if (PC_POW2) begin
        tgt_nxt = div_a[PCW-1:0];
      end else begin
        div_start = 1'b1;
      end
    end
    tgt_rdy_nxt = pc_go && PC_POW2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      bp_r      <= PW'(STACK_DEPTH - 1);
      sp_r      <= PW'(STACK_DEPTH);
      halt_r    <= 1'b0;
      fault_r   <= FLT_NONE;
      clr_r     <= '0;
      tgt_rdy_r <= 1'b0;
    end else begin
      pc_r      <= pc_nxt;
      bp_r      <= bp_nxt;
      sp_r      <= sp_nxt;
      halt_r    <= halt_nxt;
      fault_r   <= fault_nxt;
      clr_r     <= clr_nxt;
      tgt_rdy_r <= tgt_rdy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    lev_r    <= lev_nxt;
    m_r      <= m_nxt;
    rv_r     <= rv_nxt;
    b_r      <= b_nxt;
    a_r      <= a_nxt;
    c_r      <= c_nxt;
    nbp_r    <= nbp_nxt;
    res_r    <= res_nxt;
    wv_r     <= wv_nxt;
    wval_r   <= wval_nxt;
    opc_r    <= opc_nxt;
    obp_r    <= obp_nxt;
    osp_r    <= osp_nxt;
    owv_r    <= owv_nxt;
    owval_r  <= owval_nxt;
    ohalt_r  <= ohalt_nxt;
    ofault_r <= ofault_nxt;
    tgt_r    <= tgt_nxt;
  end

  pcsm_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  pcsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sgn      (div_sgn),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_rm)
  );

  assign res_pc    = opc_r;
  assign res_bp    = obp_r;
  assign res_sp    = osp_r;
  assign res_wv    = owv_r;
  assign res_wval  = owval_r;
  assign res_halt  = ohalt_r;
  assign res_fault = ofault_r;

endmodule

`default_nettype wire

// ===== sv/pcsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcsm_ctrl
// Controller: sequences one instruction as a series of micro-operations and
// owns the input/output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pcsm_pkg::status_t st,
  output pcsm_pkg::uop_t         uop,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready
);

  import pcsm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    uop           = U_NOP;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      S_CLEAR: begin
        uop = U_CLEAR;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          uop       = U_ACCEPT;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_EMIT;
        if (!st.held) begin
          case (st.op)
            OP_LIT:   uop = st.ok_spm1 ? U_PUSH_M : U_FAULT;
            OP_READ:  uop = st.ok_spm1 ? U_PUSH_RV : U_FAULT;
            OP_INC:   uop = st.ok_inc ? U_INC : U_FAULT;
            OP_HALT:  uop = U_HALT;
            OP_JMP: begin
              uop       = U_MOD_M;
              state_nxt = S_PC_WAIT;
            end
            OP_JPC: begin
              uop = U_FAULT;
              if (st.ok_sp) begin
                uop       = U_RD_SP;
                state_nxt = S_JPC;
              end
            end
            OP_WRITE: begin
              uop = U_FAULT;
              if (st.ok_sp) begin
                uop       = U_RD_SP;
                state_nxt = S_WRITE;
              end
            end
            OP_LOD, OP_STO, OP_CAL: state_nxt = S_WALK;
            OP_OPR: begin
              uop = U_FAULT;
              if (st.opr_ret) begin
                if (st.ok_bp3) begin
                  uop       = U_RD_BP2;
                  state_nxt = S_RET1;
                end
              end else if (st.opr_un) begin
                if (st.ok_sp) begin
                  uop       = U_RD_SP;
                  state_nxt = S_UN;
                end
              end else if (st.opr_bin) begin
                if (st.ok_sp && st.ok_spp1) begin
                  uop       = U_RD_SP;
                  state_nxt = S_BIN1;
                end
              end else begin
                uop = U_ADV;
              end
            end
            default: uop = U_ADV;
          endcase
        end
      end
      S_WALK: begin
        if (st.lev_zero) begin
          uop       = U_FAULT;
          state_nxt = S_EMIT;
          case (st.op)
            OP_LOD: begin
              if (st.ok_bm && st.ok_spm1) begin
                uop       = U_RD_BM;
                state_nxt = S_LOD_WR;
              end
            end
            OP_STO: begin
              if (st.ok_bm && st.ok_sp) begin
                uop       = U_RD_SP;
                state_nxt = S_STO_WR;
              end
            end
            default: begin
              if (st.ok_sp4) begin
                uop       = U_CAL_W1;
                state_nxt = S_CAL2;
              end
            end
          endcase
        end else if (st.ok_walk) begin
          uop       = U_WALK_RD;
          state_nxt = S_WALK_LD;
        end else begin
          uop       = U_FAULT;
          state_nxt = S_EMIT;
        end
      end
      S_WALK_LD: begin
        uop       = U_WALK_LD;
        state_nxt = S_WALK;
      end
      S_LOD_WR: begin
        uop       = U_LOD_WR;
        state_nxt = S_EMIT;
      end
      S_STO_WR: begin
        uop       = U_STO_WR;
        state_nxt = S_EMIT;
      end
      S_CAL2: begin
        uop       = U_CAL_W2;
        state_nxt = S_CAL3;
      end
      S_CAL3: begin
        uop       = U_CAL_W3;
        state_nxt = S_CAL4;
      end
      S_CAL4: begin
        uop       = U_CAL_W4;
        state_nxt = S_PC_WAIT;
      end
      S_JPC: begin
        if (st.rd_zero) begin
          uop       = U_JPC_TAKE;
          state_nxt = S_PC_WAIT;
        end else begin
          uop       = U_JPC_SKIP;
          state_nxt = S_EMIT;
        end
      end
      S_WRITE: begin
        uop       = U_WRITE_OUT;
        state_nxt = S_EMIT;
      end
      S_RET1: begin
        uop       = U_RD_BP3;
        state_nxt = S_RET2;
      end
      S_RET2: begin
        if (st.ok_nbp) begin
          uop       = U_RET_GO;
          state_nxt = S_PC_WAIT;
        end else begin
          uop       = U_FAULT;
          state_nxt = S_EMIT;
        end
      end
      S_UN: begin
        uop       = U_UN_WR;
        state_nxt = S_EMIT;
      end
      S_BIN1: begin
        uop       = U_LD_C;
        state_nxt = S_BIN2;
      end
      S_BIN2: begin
        uop       = U_LD_A;
        state_nxt = S_BIN3;
      end
      S_BIN3: begin
        if (st.opr_divmod) begin
          if (st.c_zero) begin
            uop       = U_BIN_DIV0;
            state_nxt = S_EMIT;
          end else begin
            uop       = U_BIN_DIV;
            state_nxt = S_DIV_WAIT;
          end
        end else begin
          uop       = U_BIN_ALU;
          state_nxt = S_BIN4;
        end
      end
      S_BIN4: begin
        uop       = U_BIN_WR;
        state_nxt = S_EMIT;
      end
      S_DIV_WAIT: begin
        if (st.div_done) begin
          uop       = U_BIN_DIVRES;
          state_nxt = S_EMIT;
        end
      end
      S_PC_WAIT: begin
        if (st.div_done) begin
          uop       = U_SET_PC;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          uop           = U_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/pcode_stack_machine_core_unit.sv =====
// ----------------------------------------------------------------------------
// pcode_stack_machine_core_unit
// Execution core of a PL/0-style p-code stack machine.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  stream: one instruction per request (op, level, operand, read value).
//   out_* stream: one result per instruction (next pc, base and stack
//         pointers, written value, halt, fault).
//   After reset the data stack is zeroed, one word a cycle, and in_tready
//   stays low until that is done.
//   One instruction is in flight at a time. Load, store and call first walk
//   one static link per level; divide and modulo use the 32-step iterative
//   divider. Branch targets are masked to CODE_DEPTH; a code depth that is
//   not a power of two reduces them in the divider instead. The next
//   request is accepted in the idle state that follows once the result is
//   registered, so no new instruction is taken before the previous result
//   is registered.
//   The result sits in an output register: the core stalls only when a new
//   result is ready and the previous one has not been taken.
//   After halt or a fault, instructions are consumed and report held state.
// ----------------------------------------------------------------------------
`default_nettype none

module pcode_stack_machine_core_unit #(
  parameter int STACK_DEPTH = 1024,
  parameter int CODE_DEPTH  = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // op[3:0], level[7:4], operand_m[39:8], read_value[71:40]
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // next_pc[8:0], base_ptr[19:9], stack_ptr[30:20], write_valid[31],
  // write_value[63:32], halted[64], fault[66:65], zero[71:67]
  output logic      [71:0] out_tdata
);

  import pcsm_pkg::*;

  uop_t        uop;
  status_t     st;
  logic [8:0]  res_pc;
  logic [10:0] res_bp;
  logic [10:0] res_sp;
  logic        res_wv;
  logic [31:0] res_wval;
  logic        res_halt;
  logic [1:0]  res_fault;

  pcsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .st         (st),
    .uop        (uop),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  pcsm_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .CODE_DEPTH  (CODE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .uop       (uop),
    .st        (st),
    .in_op     (in_tdata[3:0]),
    .in_level  (in_tdata[7:4]),
    .in_m      (in_tdata[39:8]),
    .in_rv     (in_tdata[71:40]),
    .res_pc    (res_pc),
    .res_bp    (res_bp),
    .res_sp    (res_sp),
    .res_wv    (res_wv),
    .res_wval  (res_wval),
    .res_halt  (res_halt),
    .res_fault (res_fault)
  );

  assign out_tdata = {5'd0, res_fault, res_halt, res_wval, res_wv,
                      res_sp, res_bp, res_pc};

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted while one is in flight");

  a_no_write_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res_halt || res_fault != FLT_NONE) |-> !res_wv)
    else $error("write reported together with halt or fault");

  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_fault != 2'd3)
    else $error("undefined fault code");

endmodule

`default_nettype wire

// ===== dv/pcode_stack_machine_core_unit_test.sv =====
// ----------------------------------------------------------------------------
// pcode_stack_machine_core_unit_test
// Self-checking bench for the p-code stack machine core. A short table of
// instructions is run first, then generated programs that keep the machine
// healthy (candidates that would fault or halt are retried), and finally one
// terminating event (divide by zero, stack range, or halt) followed by
// instructions that must report the held state. Every result is checked
// field by field against a behavioral model of the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcode_stack_machine_core_unit_test;
  import pcsm_pkg::*;

  localparam int  DEPTH     = 1024;
  localparam int  N_RAND    = 1700;
  localparam int  CYC_LIMIT = 1000000;

  typedef struct packed {
    logic [31:0] rv;
    logic [31:0] m;
    logic [3:0]  lev;
    logic [3:0]  op;
  } instr_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [1:0]  fault;
    logic        halted;
    logic [31:0] wval;
    logic        wv;
    logic [10:0] sp;
    logic [10:0] bp;
    logic [8:0]  pc;
  } status_word_t;

  typedef struct {
    instr_t     ins;
    bit         chk;
    bit         chk_ptr;
    bit [8:0]   pc;
    bit [10:0]  sp;
    bit [1:0]   flt;
    bit         hlt;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;

  pcode_stack_machine_core_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // machine model
  bit [31:0]    stk [DEPTH];
  bit [31:0]    stk_sv [DEPTH];
  bit [8:0]     m_pc;
  longint       m_bp, m_sp;
  bit           m_hlt;
  bit [1:0]     m_flt;

  status_word_t pending_results[$];
  row_t         dir_q[$];
  int           errors = 0;
  int           cyc = 0;
  int           s_idle = 0;
  int           r_idle = 0;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_cnt = 0;

  function automatic bit in_rng(longint i);
    return i >= 0 && i < DEPTH;
  endfunction

  function automatic longint sx(bit [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic bit walk_links(bit [3:0] lev, output longint b);
    int k;
    b = m_bp;
    for (k = 0; k < lev; k++) begin
      if (!in_rng(b - 1)) return 1'b0;
      b = sx(stk[b - 1]);
    end
    return 1'b1;
  endfunction

  function automatic status_word_t status_now(bit wv, bit [31:0] wval);
    status_word_t o;
    o.pad    = '0;
    o.fault  = m_flt;
    o.halted = m_hlt;
    o.wval   = wv ? wval : 32'd0;
    o.wv     = wv;
    o.sp     = m_sp[10:0];
    o.bp     = m_bp[10:0];
    o.pc     = m_pc;
    return o;
  endfunction

  function automatic status_word_t exec_instr(instr_t it);
    longint    m, sp, bp, b, a, c, r, nbp;
    bit [8:0]  npc;
    bit        rng, wv;
    bit [31:0] wval;
    m = sx(it.m);
    sp = m_sp;
    bp = m_bp;
    npc = m_pc + 9'd1;
    rng = 1'b0;
    wv = 1'b0;
    wval = '0;
    r = 0;
    if (m_hlt || m_flt != FLT_NONE) return status_now(1'b0, 32'd0);
    case (it.op)
      OP_LIT: begin
        if (!in_rng(sp - 1)) rng = 1'b1;
        else begin
          stk[sp - 1] = it.m;
          m_sp = sp - 1;
        end
      end
      OP_OPR: begin
        if (m == OPR_RET) begin
          if (!in_rng(bp - 3) || !in_rng(bp - 2)) rng = 1'b1;
          else begin
            nbp = sx(stk[bp - 2]);
            if (!in_rng(nbp)) rng = 1'b1;
            else begin
              npc = stk[bp - 3][8:0];
              m_sp = bp + 1;
              m_bp = nbp;
            end
          end
        end else if (m == OPR_NEG || m == OPR_ODD) begin
          if (!in_rng(sp)) rng = 1'b1;
          else if (m == OPR_NEG) stk[sp] = 32'd0 - stk[sp];
          else stk[sp] = stk[sp] & 32'd1;
        end else if (m >= OPR_ADD && m <= OPR_GEQ) begin
          if (!in_rng(sp + 1) || !in_rng(sp)) rng = 1'b1;
          else begin
            a = sx(stk[sp + 1]);
            c = sx(stk[sp]);
            case (m)
              OPR_ADD: r = a + c;
              OPR_SUB: r = a - c;
              OPR_MUL: r = a * c;
              OPR_DIV: if (c == 0) begin r = 0; m_flt = FLT_DIV0; end else r = a / c;
              OPR_MOD: if (c == 0) begin r = 0; m_flt = FLT_DIV0; end else r = a % c;
              OPR_EQL: r = a == c;
              OPR_NEQ: r = a != c;
              OPR_LSS: r = a < c;
              OPR_LEQ: r = a <= c;
              OPR_GTR: r = a > c;
              default: r = a >= c;
            endcase
            stk[sp + 1] = r[31:0];
            m_sp = sp + 1;
          end
        end
      end
      OP_LOD: begin
        if (!walk_links(it.lev, b) || !in_rng(b - m) || !in_rng(sp - 1)) rng = 1'b1;
        else begin
          stk[sp - 1] = stk[b - m];
          m_sp = sp - 1;
        end
      end
      OP_STO: begin
        if (!walk_links(it.lev, b) || !in_rng(b - m) || !in_rng(sp)) rng = 1'b1;
        else begin
          stk[b - m] = stk[sp];
          m_sp = sp + 1;
        end
      end
      OP_CAL: begin
        if (!walk_links(it.lev, b) || !in_rng(sp - 4) || !in_rng(sp - 1)) rng = 1'b1;
        else begin
          stk[sp - 1] = 32'd0;
          stk[sp - 2] = b[31:0];
          stk[sp - 3] = bp[31:0];
          stk[sp - 4] = {23'd0, npc};
          m_bp = sp - 1;
          npc = it.m[8:0];
        end
      end
      OP_INC: begin
        if (sp - m < 0 || sp - m > DEPTH) rng = 1'b1;
        else m_sp = sp - m;
      end
      OP_JMP: npc = it.m[8:0];
      OP_JPC: begin
        if (!in_rng(sp)) rng = 1'b1;
        else begin
          if (stk[sp] == 32'd0) npc = it.m[8:0];
          m_sp = sp + 1;
        end
      end
      OP_WRITE: begin
        if (!in_rng(sp)) rng = 1'b1;
        else begin
          wv = 1'b1;
          wval = stk[sp];
          m_sp = sp + 1;
        end
      end
      OP_READ: begin
        if (!in_rng(sp - 1)) rng = 1'b1;
        else begin
          stk[sp - 1] = it.rv;
          m_sp = sp - 1;
        end
      end
      OP_HALT: m_hlt = 1'b1;
      default: ;
    endcase
    if (rng) begin
      m_flt = FLT_RANGE;
      return status_now(1'b0, 32'd0);
    end
    m_pc = npc;
    return status_now(wv, wval);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send(input instr_t it);
    in_tdata  <= it;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 99) < s_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic issue_row(input row_t rw);
    status_word_t e;
    e = exec_instr(rw.ins);
    if (rw.chk) begin
      if (e.fault != rw.flt) report("table fault", e.fault, rw.flt);
      if (e.halted != rw.hlt) report("table halted", e.halted, rw.hlt);
      if (rw.chk_ptr && e.pc != rw.pc) report("table next_pc", e.pc, rw.pc);
      if (rw.chk_ptr && e.sp != rw.sp) report("table stack_ptr", e.sp, rw.sp);
    end
    pending_results.push_back(e);
    send(rw.ins);
  endtask

  function automatic bit [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return $unsigned($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // builds one instruction that keeps the machine out of held state
  task automatic gen_healthy();
    instr_t       it;
    status_word_t e;
    bit [8:0]     pc_sv;
    longint       bp_sv, sp_sv;
    int           tries, pick;
    tries = 0;
    do begin
      it.rv  = $urandom();
      it.lev = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 2));
      it.m   = rand_word();
      pick   = $urandom_range(0, 99);
      if (pick < 20) it.op = OP_LIT;
      else if (pick < 45) begin
        it.op = OP_OPR;
        it.m  = $urandom_range(0, 15);
      end else if (pick < 55) begin
        it.op = OP_LOD;
        it.m  = $unsigned($signed($urandom_range(0, 8)) - 2);
      end else if (pick < 63) begin
        it.op = OP_STO;
        it.m  = $unsigned($signed($urandom_range(0, 8)) - 2);
      end else if (pick < 69) it.op = OP_CAL;
      else if (pick < 74) begin
        it.op = OP_INC;
        it.m  = $unsigned($signed($urandom_range(0, 10)) - 4);
      end else if (pick < 78) it.op = OP_JMP;
      else if (pick < 83) it.op = OP_JPC;
      else if (pick < 88) it.op = OP_WRITE;
      else if (pick < 95) it.op = OP_READ;
      else begin
        it.op = ($urandom_range(0, 4) == 0) ? 4'd0 : 4'($urandom_range(12, 15));
        it.m  = $urandom();
      end
      if (tries > 40) begin
        it.op = OP_JMP;
        it.m  = $urandom();
      end
      stk_sv = stk;
      pc_sv = m_pc;
      bp_sv = m_bp;
      sp_sv = m_sp;
      e = exec_instr(it);
      if (m_flt != FLT_NONE || m_hlt) begin
        stk = stk_sv;
        m_pc = pc_sv;
        m_bp = bp_sv;
        m_sp = sp_sv;
        m_flt = FLT_NONE;
        m_hlt = 1'b0;
      end
      tries++;
    end while (m_flt != FLT_NONE || m_hlt || e.fault != FLT_NONE);
    pending_results.push_back(e);
    send(it);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic row_t mk(bit [3:0] op, bit [31:0] m, bit [31:0] rv = 0);
    row_t rw;
    rw.ins     = '{rv: rv, m: m, lev: 4'd0, op: op};
    rw.chk     = 1'b0;
    rw.chk_ptr = 1'b0;
    rw.pc      = '0;
    rw.sp      = '0;
    rw.flt     = FLT_NONE;
    rw.hlt     = 1'b0;
    return rw;
  endfunction

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt  = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= r_idle);
    end
  end

  always @(posedge clk) begin
    status_word_t g, w;
    if (rst_n && out_tvalid && out_tready) begin
      g = out_tdata;
      if (pending_results.size() == 0) begin
        report("unexpected result", g.wval, 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (g.pc != w.pc) report("next_pc", g.pc, w.pc);
        if (g.bp != w.bp) report("base_ptr", g.bp, w.bp);
        if (g.sp != w.sp) report("stack_ptr", g.sp, w.sp);
        if (g.wv != w.wv) report("write_valid", g.wv, w.wv);
        if (g.wval != w.wval) report("write_value", g.wval, w.wval);
        if (g.halted != w.halted) report("halted", g.halted, w.halted);
        if (g.fault != w.fault) report("fault", g.fault, w.fault);
        if (g.pad != w.pad) report("pad", g.pad, w.pad);
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    row_t   rw;
    instr_t it;
    int     ph, k, kind;
    int     sid[3];
    int     rid[3];
    sid = '{14, 64, 0};
    rid = '{64, 14, 0};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    foreach (stk[i]) stk[i] = '0;
    m_pc  = '0;
    m_bp  = DEPTH - 1;
    m_sp  = DEPTH;
    m_hlt = 1'b0;
    m_flt = FLT_NONE;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rw = mk(OP_LIT, 32'h7fffffff);
    rw.chk = 1'b1;
    rw.chk_ptr = 1'b1;
    rw.pc = 9'd1;
    rw.sp = 11'd1023;
    dir_q.push_back(rw);
    dir_q.push_back(mk(OP_LIT, 32'd1));
    dir_q.push_back(mk(OP_OPR, OPR_ADD));
    dir_q.push_back(mk(OP_LIT, 32'h80000000));
    dir_q.push_back(mk(OP_LIT, 32'hffffffff));
    dir_q.push_back(mk(OP_OPR, OPR_DIV));
    dir_q.push_back(mk(OP_OPR, OPR_NEG));
    dir_q.push_back(mk(OP_LIT, 32'hfffffff9));
    dir_q.push_back(mk(OP_OPR, OPR_ODD));
    dir_q.push_back(mk(OP_LIT, 32'd3));
    dir_q.push_back(mk(OP_OPR, OPR_MOD));
    dir_q.push_back(mk(OP_LIT, 32'hfffffffb));
    dir_q.push_back(mk(OP_OPR, OPR_MUL));
    dir_q.push_back(mk(OP_OPR, OPR_LSS));
    dir_q.push_back(mk(OP_READ, 32'h0, 32'hdeadbeef));
    dir_q.push_back(mk(OP_WRITE, 32'h0));
    dir_q.push_back(mk(4'd0, 32'hffffffff, 32'hffffffff));
    dir_q.push_back(mk(4'd15, 32'h0));
    dir_q.push_back(mk(OP_OPR, 32'd14));
    dir_q.push_back(mk(OP_INC, 32'd2));
    dir_q.push_back(mk(OP_INC, 32'hfffffffe));
    dir_q.push_back(mk(OP_LIT, 32'd0));
    dir_q.push_back(mk(OP_JPC, 32'hffffffff));
    dir_q.push_back(mk(OP_JMP, 32'h200));
    dir_q.push_back(mk(OP_CAL, 32'd5));
    dir_q.push_back(mk(OP_OPR, OPR_RET));

    s_idle = sid[0];
    r_idle = rid[0];
    foreach (dir_q[i]) issue_row(dir_q[i]);

    for (ph = 0; ph < 3; ph++) begin
      s_idle = sid[ph];
      r_idle = rid[ph];
      if (ph == 2) hold_req++;
      for (k = 0; k < N_RAND / 3; k++) gen_healthy();
      in_tvalid <= 1'b0;
      drain();
    end

    // one terminating event, then held-state reports
    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      issue_row(mk(OP_LIT, 32'd9));
      issue_row(mk(OP_LIT, 32'd0));
      rw = mk(OP_OPR, OPR_DIV);
      rw.flt = FLT_DIV0;
    end else if (kind == 1) begin
      rw = mk(OP_INC, 32'hfffff830);
      rw.flt = FLT_RANGE;
    end else begin
      rw = mk(OP_HALT, 32'd0);
      rw.hlt = 1'b1;
    end
    rw.chk = 1'b1;
    issue_row(rw);
    for (k = 0; k < 20; k++) begin
      it = {$urandom(), $urandom(), 8'($urandom())};
      pending_results.push_back(exec_instr(it));
      send(it);
    end
    in_tvalid <= 1'b0;
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
